### rtl/core/rbf_pkg.sv
// Shared types and constants for the ring byte FIFO.
package rbf_pkg;

    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 4;
    localparam int DATA_W   = 64;
    localparam int LEVEL_W  = 12;
    localparam int CONT_W   = 13;
    localparam int MOD_W    = 13;

    typedef enum logic [ACTION_W-1:0] {
        OP_WRITE      = 2'd0,
        OP_READ       = 2'd1,
        OP_FLUSH      = 2'd2,
        OP_COND_RESET = 2'd3
    } t_op;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0]  byte_count;
        logic [DATA_W-1:0]   write_data;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] bytes_done;
        logic [DATA_W-1:0]  read_data;
        logic [LEVEL_W-1:0] bytes_used;
        logic [LEVEL_W-1:0] bytes_free;
        logic [CONT_W-1:0]  contiguous_read;
        logic [CONT_W-1:0]  contiguous_write;
        logic               reset_done;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  data;
    } t_cmd;

endpackage

### rtl/core/rbf_front.sv
// Front end: accepts input beats, decodes the action and clamps the byte count.
module rbf_front import rbf_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_q_full,
    input  logic  i_busy,
    output logic  o_full,
    output logic  o_q_push,
    output t_cmd  o_cmd
);

    logic [COUNT_W-1:0] clamp_count;

    assign o_full   = i_q_full || i_busy;
    assign o_q_push = i_push && !o_full;

    // Requests beyond the lane count are cut down to a full burst.
    assign clamp_count = (i_item.byte_count > COUNT_W'(LANES)) ? COUNT_W'(LANES)
                                                                : i_item.byte_count;

    always_comb begin
        o_cmd.data  = i_item.write_data;
        o_cmd.count = clamp_count;
        unique case (i_item.action)
            OP_WRITE:      o_cmd.op = OP_WRITE;
            OP_READ:       o_cmd.op = OP_READ;
            OP_FLUSH:      o_cmd.op = OP_FLUSH;
            default:       o_cmd.op = OP_COND_RESET;
        endcase
    end

endmodule

### rtl/core/rbf_cmd_queue.sv
// Two-entry command queue between the front end and the execution engine.
module rbf_cmd_queue import rbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/rbf_size_div.sv
// Usable-size calculation: restoring division of the store depth by the frame modulus.
module rbf_size_div import rbf_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [MOD_W-1:0]           i_modulus,
    output logic                       o_busy,
    output logic                       o_load,
    output logic [$clog2(DEPTH+1)-1:0] o_usable
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int BW = $clog2(DW);
    localparam logic [DW-1:0] DEPTH_V = DW'(DEPTH);

    logic             r_busy;
    logic             r_load;
    logic [BW-1:0]    r_bit;
    logic [MOD_W-1:0] r_mod;
    logic [MOD_W-1:0] r_rem;
    logic [DW-1:0]    r_usable;
    logic [MOD_W:0]   trial;
    logic [MOD_W-1:0] n_rem;
    logic [31:0]      usable_32;

    // The remainder always stays below the modulus, so the trial value never
    // needs more than one bit over the modulus width.
    always_comb begin
        trial = {r_rem, DEPTH_V[r_bit]};
        if (trial >= {1'b0, r_mod}) begin
            n_rem = MOD_W'(trial - {1'b0, r_mod});
        end else begin
            n_rem = trial[MOD_W-1:0];
        end
        usable_32 = 32'(DEPTH) - 32'(n_rem);
    end

    assign o_busy   = r_busy || r_load;
    assign o_load   = r_load;
    assign o_usable = r_usable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_load <= 1'b0;
            if (r_busy) begin
                r_bit <= r_bit - BW'(1);
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_load <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= BW'(DW - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            if (r_bit == '0) begin
                r_usable <= usable_32[DW-1:0];
            end
        end else if (i_start) begin
            r_rem <= '0;
            r_mod <= (i_modulus == '0) ? MOD_W'(1) : i_modulus;
        end
    end

endmodule

### rtl/core/rbf_engine.sv
// Execution engine: byte store, pointers, per-byte transfers and result register.
module rbf_engine import rbf_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int LANES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  t_cmd                       i_cmd,
    output logic                       o_q_pop,
    input  logic                       i_load,
    input  logic [$clog2(DEPTH+1)-1:0] i_usable,
    input  logic                       i_pop,
    output logic                       o_res_valid,
    output t_result                    o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = $clog2(DEPTH + 1);
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic [COUNT_W-1:0]   r_done, n_done;
    logic [LW-1:0]        r_lane, n_lane;
    logic [LW-1:0]        r_cap_lane, n_cap_lane;
    logic                 r_rd_pend, n_rd_pend;
    logic                 r_rst_done, n_rst_done;
    logic [DATA_W-1:0]    r_wdata, n_wdata;
    logic [LANES*8-1:0]   r_rdata, n_rdata;
    logic [AW-1:0]        r_rp, n_rp;
    logic [AW-1:0]        r_wp, n_wp;
    logic [DW-1:0]        r_used, n_used;
    logic [DW-1:0]        r_usable, n_usable;
    t_result              r_res, n_res;
    logic                 r_res_valid, n_res_valid;

    logic [7:0]           mem [DEPTH];
    logic [7:0]           r_mem_q;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;

    logic [DW-1:0]        free;
    logic [DW-1:0]        limit;
    logic [DW-1:0]        ptr_inc;
    logic [AW-1:0]        ptr_adv;
    logic [COUNT_W-1:0]   grant;
    logic [31:0]          cont_rd_32;
    logic [31:0]          cont_wr_32;
    logic [31:0]          used_32;
    logic [31:0]          free_32;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // One slot is always kept empty; a usable size of zero leaves no free space at all.
    assign free = (r_usable == '0) ? '0 : (r_usable - DW'(1) - r_used);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_left      = r_left;
        n_done      = r_done;
        n_lane      = r_lane;
        n_cap_lane  = r_cap_lane;
        n_rd_pend   = 1'b0;
        n_rst_done  = r_rst_done;
        n_wdata     = r_wdata;
        n_rdata     = r_rdata;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_used      = r_used;
        n_usable    = r_usable;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_pop;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = (r_op == OP_WRITE) ? r_wp : r_rp;
        limit       = '0;
        grant       = '0;
        used_32     = 32'(r_used);
        free_32     = 32'(free);
        cont_rd_32  = '0;
        cont_wr_32  = '0;

        // The read pointer moves on a read, the write pointer on a write.
        ptr_inc = DW'((r_op == OP_WRITE) ? r_wp : r_rp) + DW'(1);
        ptr_adv = (ptr_inc == r_usable) ? '0 : ptr_inc[AW-1:0];

        // Store data for the byte read in the previous cycle lands in its lane.
        if (r_rd_pend) begin
            n_rdata[r_cap_lane*8 +: 8] = r_mem_q;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop    = 1'b1;
                    n_op       = i_cmd.op;
                    n_wdata    = i_cmd.data;
                    n_rdata    = '0;
                    n_lane     = '0;
                    n_rst_done = 1'b0;
                    n_done     = '0;
                    n_state    = S_FINISH;
                    limit      = (i_cmd.op == OP_WRITE) ? free : r_used;
                    grant      = (DW'(i_cmd.count) < limit) ? i_cmd.count
                                                            : limit[COUNT_W-1:0];
                    unique case (i_cmd.op)
                        OP_WRITE, OP_READ: begin
                            n_done = grant;
                            n_left = grant;
                            if (grant != '0) begin
                                n_state = S_XFER;
                            end
                        end
                        OP_FLUSH: begin
                            n_rp       = '0;
                            n_wp       = '0;
                            n_used     = '0;
                            n_rst_done = 1'b1;
                        end
                        default: begin
                            if (r_rp == r_wp) begin
                                n_rp       = '0;
                                n_wp       = '0;
                                n_used     = '0;
                                n_rst_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_XFER: begin
                if (r_op == OP_WRITE) begin
                    mem_we  = 1'b1;
                    n_wdata = r_wdata >> 8;
                    n_wp    = ptr_adv;
                    n_used  = r_used + DW'(1);
                end else begin
                    n_rd_pend  = 1'b1;
                    n_cap_lane = r_lane;
                    n_rp       = ptr_adv;
                    n_used     = r_used - DW'(1);
                end
                n_lane = r_lane + LW'(1);
                n_left = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1)) begin
                    n_state = (r_op == OP_READ) ? S_DRAIN : S_FINISH;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            default: begin
                if (r_wp >= r_rp) begin
                    cont_rd_32 = 32'(r_wp) - 32'(r_rp);
                    cont_wr_32 = (32'(r_usable) > 32'(r_wp)) ? 32'(r_usable) - 32'(r_wp)
                                                               : '0;
                end else begin
                    cont_rd_32 = 32'(r_usable) - 32'(r_rp);
                    cont_wr_32 = 32'(r_rp) - 32'(r_wp);
                end
                if (!r_res_valid || i_pop) begin
                    n_res.bytes_done       = r_done;
                    n_res.read_data        = DATA_W'(r_rdata);
                    n_res.bytes_used       = used_32[LEVEL_W-1:0];
                    n_res.bytes_free       = free_32[LEVEL_W-1:0];
                    n_res.contiguous_read  = cont_rd_32[CONT_W-1:0];
                    n_res.contiguous_write = cont_wr_32[CONT_W-1:0];
                    n_res.reset_done       = r_rst_done;
                    n_res_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
        endcase

        // The user must load a new usable size only while the engine is idle; the engine does not enforce it.
        if (i_load) begin
            n_usable = i_usable;
            n_rp     = '0;
            n_wp     = '0;
            n_used   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_used      <= '0;
            r_usable    <= DW'(DEPTH);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_used      <= n_used;
            r_usable    <= n_usable;
            r_res_valid <= n_res_valid;
        end
        r_op       <= n_op;
        r_left     <= n_left;
        r_done     <= n_done;
        r_lane     <= n_lane;
        r_cap_lane <= n_cap_lane;
        r_rst_done <= n_rst_done;
        r_wdata    <= n_wdata;
        r_rdata    <= n_rdata;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_wdata[7:0];
        end
        r_mem_q <= mem[mem_addr];
    end

endmodule

### rtl/core/ring_byte_fifo.sv
// Top level of the ring byte FIFO: front end, command queue, size divider and engine.
//
// A circular byte FIFO over a single-port store of DEPTH bytes that always keeps one
// slot empty. Each input beat carries one action: write up to LANES bytes (clamped to
// the free space), read up to LANES bytes (clamped to the bytes held, lane 0 oldest,
// unused lanes zero), flush, or clear the pointers only when the FIFO is empty. Every
// input beat yields exactly one result beat carrying the status after that action.
// Input beats are taken into a two-entry command queue, so until it is full the front
// keeps accepting while the engine works or while a finished result waits to be popped.
// The engine moves one byte per cycle through the store's single port in its transfer
// state, then a write goes to finish and a read to finish through a drain state; flush,
// conditional reset or a transfer clamped to zero bytes go from idle straight to finish.
// Writing the frame modulus sets the usable size to the largest multiple of the modulus
// that fits the store and clears both pointers; a modulus of zero counts as one and a
// modulus above DEPTH leaves no usable space. That size is computed one quotient bit per
// cycle, so the write holds the configuration port and the input side off until it is
// loaded. Configuration is to be written only while the FIFO has no work in flight.
module ring_byte_fifo import rbf_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int LANES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_item            i_item,
    output logic             empty,
    input  logic             pop,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MOD_W-1:0] i_cfg_data
);

    localparam int DW = $clog2(DEPTH + 1);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    t_cmd          front_cmd;
    t_cmd          q_cmd;
    logic          div_busy;
    logic          div_load;
    logic [DW-1:0] div_usable;
    logic          res_valid;

    // The size divider owns the configuration port; while it runs, no input beat is
    // taken so that the engine sees the new size before any further command.
    assign o_cfg_ready = !div_busy;
    assign empty       = !res_valid;

    rbf_front #(
        .LANES (LANES)
    ) u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .i_busy   (div_busy),
        .o_full   (full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    rbf_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // A division starts only on an accepted configuration beat.
    rbf_size_div #(
        .DEPTH (DEPTH)
    ) u_size_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cfg_valid && o_cfg_ready),
        .i_modulus (i_cfg_data),
        .o_busy    (div_busy),
        .o_load    (div_load),
        .o_usable  (div_usable)
    );

    // The engine holds its result in an output register, which is the result queue
    // as seen from outside: empty is low while that register holds a beat.
    rbf_engine #(
        .DEPTH (DEPTH),
        .LANES (LANES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .i_load      (div_load),
        .i_usable    (div_usable),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (o_result)
    );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the ring byte FIFO with a built-in status predictor.
module tb_top;
    import rbf_pkg::*;

    localparam int DEPTH = 4096;
    localparam int LANES = 8;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    t_item               item_bus    = '0;
    logic                empty;
    logic                pop         = 1'b0;
    t_result             o_result;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [MOD_W-1:0]    i_cfg_data  = '0;

    ring_byte_fifo #(.DEPTH(DEPTH), .LANES(LANES)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (item_bus),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mirror of the FIFO: byte store, both pointers and the usable size.
    logic [7:0]        shadow_mem [DEPTH];
    logic [CONT_W-1:0] rd_ptr = '0;
    logic [CONT_W-1:0] wr_ptr = '0;
    logic [CONT_W-1:0] span   = CONT_W'(DEPTH);

    t_result awaited_status[$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  settings_used = 1;
    int  write_clamps  = 0;
    int  ptr_wraps     = 0;
    int  ptr_clears    = 0;
    bit  steady        = 1'b0;

    function automatic int held();
        if (wr_ptr >= rd_ptr) return int'(wr_ptr) - int'(rd_ptr);
        return int'(span) - (int'(rd_ptr) - int'(wr_ptr));
    endfunction

    function automatic int room();
        int u;
        u = held();
        if (int'(span) < u + 1) return 0;
        return int'(span) - u - 1;
    endfunction

    function automatic int run_to_wrap();
        if (wr_ptr >= rd_ptr) return int'(wr_ptr) - int'(rd_ptr);
        return int'(span) - int'(rd_ptr);
    endfunction

    function automatic int gap_to_wrap();
        if (wr_ptr >= rd_ptr) return (span > wr_ptr) ? int'(span) - int'(wr_ptr) : 0;
        return int'(rd_ptr) - int'(wr_ptr);
    endfunction

    function automatic int bump(input int p, input int by);
        if (p + by >= int'(span)) return p + by - int'(span);
        return p + by;
    endfunction

    // Applies one action to the mirror and returns the status the FIFO must report.
    function automatic t_result fifo_step(input t_item it);
        t_result r;
        int      cnt;
        int      take;
        r    = '0;
        take = 0;
        cnt  = (int'(it.byte_count) > LANES) ? LANES : int'(it.byte_count);
        case (t_op'(it.action))
            OP_WRITE: begin
                take = (cnt < room()) ? cnt : room();
                if (take < cnt) write_clamps++;
                for (int i = 0; i < take; i++)
                    shadow_mem[bump(int'(wr_ptr), i)] = it.write_data[8*i +: 8];
                if (take > 0 && int'(wr_ptr) + take >= int'(span)) ptr_wraps++;
                wr_ptr = CONT_W'(bump(int'(wr_ptr), take));
            end
            OP_READ: begin
                take = (cnt < held()) ? cnt : held();
                for (int i = 0; i < take; i++)
                    r.read_data[8*i +: 8] = shadow_mem[bump(int'(rd_ptr), i)];
                if (take > 0 && int'(rd_ptr) + take >= int'(span)) ptr_wraps++;
                rd_ptr = CONT_W'(bump(int'(rd_ptr), take));
            end
            OP_FLUSH: begin
                rd_ptr = '0;
                wr_ptr = '0;
                r.reset_done = 1'b1;
                ptr_clears++;
            end
            default: begin
                // Conditional reset only acts on an empty FIFO.
                if (rd_ptr == wr_ptr) begin
                    rd_ptr = '0;
                    wr_ptr = '0;
                    r.reset_done = 1'b1;
                    ptr_clears++;
                end
            end
        endcase
        r.bytes_done       = COUNT_W'(take);
        r.bytes_used       = LEVEL_W'(held());
        r.bytes_free       = LEVEL_W'(room());
        r.contiguous_read  = CONT_W'(run_to_wrap());
        r.contiguous_write = CONT_W'(gap_to_wrap());
        return r;
    endfunction

    function automatic t_item make_item(input t_op op, input int cnt, input logic [63:0] d);
        t_item it;
        it.action     = op;
        it.byte_count = COUNT_W'(cnt);
        it.write_data = d;
        return it;
    endfunction

    // Random action with the given odds in percent; what is left over is conditional reset.
    function automatic t_item draw_item(input int wr_pct, input int rd_pct, input int fl_pct,
                                        input int lo);
        t_item it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < wr_pct)                       it.action = OP_WRITE;
        else if (roll < wr_pct + rd_pct)         it.action = OP_READ;
        else if (roll < wr_pct + rd_pct + fl_pct) it.action = OP_FLUSH;
        else                                     it.action = OP_COND_RESET;
        if ($urandom_range(0, 9) == 0) it.byte_count = COUNT_W'($urandom_range(9, 15));
        else                           it.byte_count = COUNT_W'($urandom_range(lo, 8));
        it.write_data = {$urandom, $urandom};
        return it;
    endfunction

    // Sends one beat. It is entered at a rising edge and returns at the accepting edge with
    // push still high, so back-to-back beats never lower and raise push in one step.
    task automatic send_item(input t_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        item_bus <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        awaited_status.push_back(fifo_step(it));
        items_sent++;
    endtask

    // Writes the frame modulus once the FIFO has drained every result.
    task automatic set_modulus(input int m);
        int eff;
        push <= 1'b0;
        wait (awaited_status.size() == 0);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= MOD_W'(m);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        eff    = (m == 0) ? 1 : m;
        span   = CONT_W'((DEPTH / eff) * eff);
        rd_ptr = '0;
        wr_ptr = '0;
        settings_used++;
    endtask

    task automatic note_miss(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s of result %0d: expected %h, got %h",
                     what, results_seen, want, got);
    endtask

    // Result side: pops with random stalls and checks each beat against the oldest status.
    initial begin : result_checker
        t_result want;
        int      hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
                results_seen++;
                if (awaited_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = awaited_status.pop_front();
                    if (o_result.bytes_done !== want.bytes_done)
                        note_miss("bytes_done", want.bytes_done, o_result.bytes_done);
                    if (o_result.read_data !== want.read_data)
                        note_miss("read_data", want.read_data, o_result.read_data);
                    if (o_result.bytes_used !== want.bytes_used)
                        note_miss("bytes_used", want.bytes_used, o_result.bytes_used);
                    if (o_result.bytes_free !== want.bytes_free)
                        note_miss("bytes_free", want.bytes_free, o_result.bytes_free);
                    if (o_result.contiguous_read !== want.contiguous_read)
                        note_miss("contiguous_read", want.contiguous_read,
                                  o_result.contiguous_read);
                    if (o_result.contiguous_write !== want.contiguous_write)
                        note_miss("contiguous_write", want.contiguous_write,
                                  o_result.contiguous_write);
                    if (o_result.reset_done !== want.reset_done)
                        note_miss("reset_done", want.reset_done, o_result.reset_done);
                end
                hold = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Edges of the fields at the reset size: empty and non-empty clears, clamping of
    // counts above eight, zero counts, and all-ones and all-zeros data.
    task automatic test_directed();
        send_item(make_item(OP_COND_RESET, 0, '0));
        send_item(make_item(OP_READ, 8, '0));
        send_item(make_item(OP_WRITE, 0, '1));
        send_item(make_item(OP_WRITE, 8, '1));
        send_item(make_item(OP_WRITE, 15, '0));
        send_item(make_item(OP_COND_RESET, 8, '1));
        send_item(make_item(OP_READ, 3, '1));
        send_item(make_item(OP_READ, 15, '0));
        send_item(make_item(OP_READ, 8, '0));
        send_item(make_item(OP_WRITE, 8, 64'h0123_4567_89ab_cdef));
        send_item(make_item(OP_FLUSH, 15, '1));
        send_item(make_item(OP_WRITE, 8, 64'hfedc_ba98_7654_3210));
        send_item(make_item(OP_READ, 9, '0));
        send_item(make_item(OP_COND_RESET, 0, '0));
    endtask

    // A modulus above the store size leaves no usable space at all.
    task automatic test_no_space();
        set_modulus(4097);
        send_item(make_item(OP_WRITE, 8, '1));
        send_item(make_item(OP_READ, 8, '0));
        send_item(make_item(OP_COND_RESET, 0, '0));
        send_item(make_item(OP_FLUSH, 0, '0));
        set_modulus(8191);
        send_item(make_item(OP_WRITE, 15, '1));
        send_item(make_item(OP_READ, 15, '0));
    endtask

    // A modulus of zero behaves as one: the whole store is usable.
    task automatic test_zero_modulus();
        set_modulus(0);
        send_item(make_item(OP_WRITE, 5, 64'h5a5a_a5a5_0f0f_f0f0));
        send_item(make_item(OP_READ, 8, '0));
        send_item(make_item(OP_COND_RESET, 0, '0));
    endtask

    // Smallest non-zero usable size: fill past full with writes, then drain past empty,
    // so both pointers wrap and every clamp is reached with random contents.
    task automatic test_fill_drain();
        int n;
        int extra;
        set_modulus(2049);
        n     = 0;
        extra = 0;
        while (extra < 60 && n < 900) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 2) == 0);
            send_item(draw_item(85, 13, 0, 4));
            if (room() == 0) extra++;
            n++;
        end
        n     = 0;
        extra = 0;
        while (extra < 30 && n < 900) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 2) == 0);
            send_item(draw_item(12, 85, 0, 4));
            if (held() == 0) extra++;
            n++;
        end
        steady = 1'b0;
    endtask

    // Mixed traffic with flushes under several frame settings, the largest among them.
    task automatic test_random_mix();
        int mods [5];
        mods = '{1, 3, 100, 4096, 0};
        mods[4] = $urandom_range(1, 4096);
        foreach (mods[k]) begin
            set_modulus(mods[k]);
            steady = (k == 2);
            repeat (40) send_item(draw_item(45, 40, 5, 0));
        end
        steady = 1'b0;
    endtask

    initial begin : watchdog
        #3_000_000;
        $display("timeout with %0d results outstanding", awaited_status.size());
        $display("status: fail");
        $finish;
    end

    initial begin : run
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_no_space();
        test_zero_modulus();
        test_fill_drain();
        test_random_mix();
        push <= 1'b0;
        wait (awaited_status.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("sent %0d actions and checked %0d results over %0d frame settings",
                 items_sent, results_seen, settings_used);
        $display("writes cut short by a full FIFO: %0d, pointer wraps: %0d, clears: %0d",
                 write_clamps, ptr_wraps, ptr_clears);
        if (mismatches == 0 && awaited_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
